FILE: hdl/cst_pkg.sv
`default_nettype none

package cst_pkg;

  // Command codes carried on in_cmd.
  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_CLOSE  = 2'd1,
    CMD_WAIT   = 2'd2,
    CMD_SIGNAL = 2'd3
  } cmd_t;

  // Status codes returned on out_status.
  typedef enum logic [1:0] {
    ST_OK             = 2'd0,
    ST_NOT_CREATED    = 2'd1,
    ST_FULL           = 2'd2,
    ST_INIT_TOO_LARGE = 2'd3
  } status_t;

  localparam int unsigned COUNT_W = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'h7FFF;
  localparam logic [COUNT_W-1:0] COUNT_MIN = 16'h8000;

  localparam int unsigned ID_W   = 4;
  localparam int unsigned INIT_W = 5;

endpackage

`default_nettype wire

FILE: hdl/counting_semaphore_table_unit.sv
`default_nettype none

// Table of counting semaphores, each with a FIFO ring of waiting task numbers.
// Request channel: drive in_cmd, in_sem_index, in_init_value and in_task_id
// and raise start; the request is taken at a clock edge where start is high
// and busy is low. Commands are create, close, wait (P) and signal (V).
// Result channel: every request yields exactly one result, shown on the out_
// ports for a single cycle while out_valid is high. The receiver cannot stall
// the block, so it must capture the result in that cycle.
// The accepting edge captures the request and reads the semaphore memory;
// the execute state writes the entry back and registers the result. A
// signal that releases a waiting task also reads the wait ring memory there
// and passes through the ring state, which registers the released task as
// the result. busy stays high until the block can take the next request, so
// a new request is never taken before the last one's result is registered.
// Reset (rst_n low, synchronous) clears all created flags, the allocation
// pointer and the control state; the memories need no clearing pass, since
// an entry is used only after a create has written it.
module counting_semaphore_table_unit #(
  parameter int NUM_SEMAPHORES = 16,
  parameter int NUM_TASKS      = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   in_cmd,
  input  wire logic [cst_pkg::ID_W-1:0]     in_sem_index,
  input  wire logic [cst_pkg::INIT_W-1:0]   in_init_value,
  input  wire logic [cst_pkg::ID_W-1:0]     in_task_id,
  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic [cst_pkg::ID_W-1:0]          out_new_index,
  output logic                              out_must_sleep,
  output logic                              out_wake_valid,
  output logic [cst_pkg::ID_W-1:0]          out_wake_task
);

  // Width of a semaphore address, of a ring position, of the allocation
  // pointer (which must also hold NUM_SEMAPHORES itself) and of a ring address.
  localparam int IW  = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
  localparam int PW  = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int NFW = $clog2(NUM_SEMAPHORES + 1);
  localparam int RD  = NUM_SEMAPHORES * NUM_TASKS;
  localparam int RAW = $clog2(RD);

  // One-hot sequencer states.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RING = 3'b100
  } state_t;

  // One semaphore table entry: signed count plus ring write and read positions.
  typedef struct packed {
    logic [cst_pkg::COUNT_W-1:0] count;
    logic [PW-1:0]               head;
    logic [PW-1:0]               tail;
  } entry_t;

  state_t state_r, state_nxt;

  // Captured request fields.
  logic [1:0]                    cmd_r;
  logic [cst_pkg::ID_W-1:0]      idx_r;
  logic [cst_pkg::INIT_W-1:0]    init_r;
  logic [cst_pkg::ID_W-1:0]      task_r;

  // Created flags live in flip-flops so that reset clears them at once.
  logic [NUM_SEMAPHORES-1:0]     created_r;
  logic [NFW-1:0]                next_free_r;

  // Semaphore entry memory and wait ring memory, both with registered reads.
  entry_t                        sem_mem [NUM_SEMAPHORES];
  entry_t                        sem_q;
  logic [cst_pkg::ID_W-1:0]      ring_mem [RD];
  logic [cst_pkg::ID_W-1:0]      ring_q;

  // Result registers.
  logic                          out_valid_r;
  logic [1:0]                    out_status_r;
  logic [cst_pkg::ID_W-1:0]      out_new_index_r;
  logic                          out_must_sleep_r;
  logic                          out_wake_valid_r;
  logic [cst_pkg::ID_W-1:0]      out_wake_task_r;

  logic                          accept;
  logic [IW-1:0]                 sem_addr;
  logic                          in_range;
  logic                          full;
  logic                          init_bad;
  logic [cst_pkg::COUNT_W-1:0]   cnt_dec;
  logic [cst_pkg::COUNT_W-1:0]   cnt_inc;
  logic                          do_sleep;
  logic                          do_wake;
  logic [PW-1:0]                 head_inc;
  logic [PW-1:0]                 tail_inc;

  // Decoded actions of the execute cycle.
  logic                          sem_we;
  logic [IW-1:0]                 sem_waddr;
  entry_t                        sem_wdata;
  logic                          ring_we;
  logic                          ring_re;
  logic [RAW-1:0]                ring_addr;
  logic                          set_created;
  logic                          clr_created;
  logic                          res_now;
  logic [1:0]                    res_status;
  logic                          res_sleep;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  assign sem_addr = IW'(idx_r);
  assign in_range = (32'(idx_r) < NUM_SEMAPHORES);
  assign full     = (32'(next_free_r) >= NUM_SEMAPHORES);
  assign init_bad = (32'(init_r) >= NUM_TASKS);

  // Count update with saturation at both ends of the 16-bit signed range.
  // A wait that leaves the count negative queues the task; a signal that
  // leaves it zero or below releases the oldest waiter.
  assign cnt_dec  = (sem_q.count != cst_pkg::COUNT_MIN) ? (sem_q.count - 1'b1) : sem_q.count;
  assign cnt_inc  = (sem_q.count != cst_pkg::COUNT_MAX) ? (sem_q.count + 1'b1) : sem_q.count;
  assign do_sleep = cnt_dec[cst_pkg::COUNT_W-1];
  assign do_wake  = cnt_inc[cst_pkg::COUNT_W-1] || (cnt_inc == '0);

  // Ring positions wrap at NUM_TASKS, which need not be a power of two.
  assign head_inc = (32'(sem_q.head) == NUM_TASKS - 1) ? '0 : (sem_q.head + 1'b1);
  assign tail_inc = (32'(sem_q.tail) == NUM_TASKS - 1) ? '0 : (sem_q.tail + 1'b1);

  always_comb begin
    sem_we      = 1'b0;
    sem_waddr   = sem_addr;
    sem_wdata   = sem_q;
    ring_we     = 1'b0;
    ring_re     = 1'b0;
    ring_addr   = RAW'(RAW'(sem_addr) * RAW'(NUM_TASKS));
    set_created = 1'b0;
    clr_created = 1'b0;
    res_now     = 1'b0;
    res_status  = cst_pkg::ST_OK;
    res_sleep   = 1'b0;
    if (state_r == S_EXEC) begin
      res_now = 1'b1;
      priority if (cmd_r == cst_pkg::CMD_CREATE) begin
        priority if (full) begin
          res_status = cst_pkg::ST_FULL;
        end else if (init_bad) begin
          res_status = cst_pkg::ST_INIT_TOO_LARGE;
        end else begin
          sem_we          = 1'b1;
          sem_waddr       = next_free_r[IW-1:0];
          sem_wdata.count = cst_pkg::COUNT_W'(init_r);
          sem_wdata.head  = '0;
          sem_wdata.tail  = '0;
          set_created     = 1'b1;
        end
      end else if (!in_range) begin
        res_status = cst_pkg::ST_NOT_CREATED;
      end else if (cmd_r == cst_pkg::CMD_CLOSE) begin
        clr_created = 1'b1;
      end else if (!created_r[sem_addr]) begin
        res_status = cst_pkg::ST_NOT_CREATED;
      end else if (cmd_r == cst_pkg::CMD_WAIT) begin
        sem_we          = 1'b1;
        sem_wdata.count = cnt_dec;
        res_sleep       = do_sleep;
        if (do_sleep) begin
          ring_we        = 1'b1;
          ring_addr      = RAW'(RAW'(sem_addr) * RAW'(NUM_TASKS)) + RAW'(sem_q.head);
          sem_wdata.head = head_inc;
        end
      end else begin
        sem_we          = 1'b1;
        sem_wdata.count = cnt_inc;
        if (do_wake) begin
          // The released task comes out of the ring in the following cycle.
          ring_re        = 1'b1;
          ring_addr      = RAW'(RAW'(sem_addr) * RAW'(NUM_TASKS)) + RAW'(sem_q.tail);
          sem_wdata.tail = tail_inc;
          res_now        = 1'b0;
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = ring_re ? S_RING : S_IDLE;
      end
      S_RING: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      created_r   <= '0;
      next_free_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= res_now || (state_r == S_RING);
      if (set_created) begin
        created_r[next_free_r[IW-1:0]] <= 1'b1;
        next_free_r                    <= next_free_r + 1'b1;
      end
      if (clr_created) begin
        created_r[sem_addr] <= 1'b0;
      end
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_cmd;
      idx_r  <= in_sem_index;
      init_r <= in_init_value;
      task_r <= in_task_id;
    end
  end

  // Semaphore entry memory: read on acceptance, written back in the execute
  // cycle. Requests never overlap, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (sem_we) begin
      sem_mem[sem_waddr] <= sem_wdata;
    end
    if (accept) begin
      sem_q <= sem_mem[IW'(in_sem_index)];
    end
  end

  // Wait ring memory, one slot group of NUM_TASKS entries per semaphore.
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_addr] <= task_r;
    end
    if (ring_re) begin
      ring_q <= ring_mem[ring_addr];
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (res_now) begin
      out_status_r     <= res_status;
      out_new_index_r  <= (set_created) ? cst_pkg::ID_W'(next_free_r) : '0;
      out_must_sleep_r <= res_sleep;
      out_wake_valid_r <= 1'b0;
      out_wake_task_r  <= '0;
    end else if (state_r == S_RING) begin
      out_status_r     <= cst_pkg::ST_OK;
      out_new_index_r  <= '0;
      out_must_sleep_r <= 1'b0;
      out_wake_valid_r <= 1'b1;
      out_wake_task_r  <= ring_q;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_new_index  = out_new_index_r;
  assign out_must_sleep = out_must_sleep_r;
  assign out_wake_valid = out_wake_valid_r;
  assign out_wake_task  = out_wake_task_r;

`ifndef SYNTHESIS
  // An accepted request always keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after an accepted request");

  // Requests are processed one at a time, so results never come back to back.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results in consecutive cycles");

  // A single request can either queue a task or release one, never both.
  a_sleep_wake_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_must_sleep && out_wake_valid))
    else $error("result both queues and releases a task");

  // A wake-up result is produced only from the ring read cycle.
  a_wake_from_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_wake_valid) |-> ($past(state_r) == S_RING))
    else $error("wake-up reported without a ring read");
`endif

endmodule

`default_nettype wire
